// ===== rtl/core/sdspi_pkg.sv =====
// Shared types and constants for the SD SPI-mode command transport.
// No dependencies; imported by all modules in rtl/core.
`default_nettype none
package sdspi_pkg;
  localparam int MaxBlockBytes   = 1024;
  localparam int WriteBlockBytes = 512;

  localparam logic [1:0] CMD_START_CMD   = 2'd0;
  localparam logic [1:0] CMD_START_READ  = 2'd1;
  localparam logic [1:0] CMD_START_WRITE = 2'd2;
  localparam logic [1:0] CMD_CARD_BYTE   = 2'd3;

  localparam logic [1:0] KIND_XFER = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BUSY_TO   = 3'd1;
  localparam logic [2:0] ST_NO_R1     = 3'd2;
  localparam logic [2:0] ST_PREFIX    = 3'd3;
  localparam logic [2:0] ST_TOKEN_TO  = 3'd4;
  localparam logic [2:0] ST_BAD_TOKEN = 3'd5;
  localparam logic [2:0] ST_WR_REJECT = 3'd6;

  localparam logic [1:0] REG_READY_POLL = 2'd0;
  localparam logic [1:0] REG_TOKEN_POLL = 2'd1;
  localparam logic [1:0] REG_RESP_POLL  = 2'd2;

  // input item, 76 bits
  typedef struct packed {
    logic [7:0]  write_byte;
    logic [7:0]  card_byte;
    logic [7:0]  data_token;
    logic [10:0] block_length;
    logic [31:0] argument;
    logic        app_command;
    logic [5:0]  command_index;
    logic [1:0]  cmd;
  } item_t;

  // result item
  typedef struct packed {
    logic       last;
    logic [7:0] response_byte;
    logic [2:0] status;
    logic [7:0] read_byte;
    logic       select_active;
    logic [7:0] send_byte;
    logic [1:0] kind;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/core/sdspi_front.sv =====
// Front end: input skid register feeding the engine.
// Depends on sdspi_pkg.
`default_nettype none
module sdspi_front
  import sdspi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       q_valid,
  input  wire logic  q_ready,
  output item_t      q_item
);
  // one-entry queue: accepts when empty or draining this cycle
  assign in_ready = !q_valid || q_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      q_item <= in_item;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sdspi_engine.sv =====
// Back end: transport state machine, emits up to two results per item
// through a small output queue. Depends on sdspi_pkg.
`default_nettype none
module sdspi_engine
  import sdspi_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES   = MaxBlockBytes,
  parameter int WRITE_BLOCK_BYTES = WriteBlockBytes
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic    q_valid,
  output logic         q_ready,
  input  wire item_t   q_item,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_item
);
  localparam int CW = $clog2(MAX_BLOCK_BYTES + 1) > 11 ? $clog2(MAX_BLOCK_BYTES + 1) : 11;
  localparam logic [CW-1:0] MaxLen = CW'(MAX_BLOCK_BYTES);
  localparam logic [CW-1:0] WrLen  = CW'(WRITE_BLOCK_BYTES);

  typedef enum logic [4:0] {
    PH_IDLE, PH_DESEL, PH_RSKIP, PH_RPOLL, PH_FRAME, PH_SKIP12, PH_R1,
    PH_TOKPOLL, PH_RDATA, PH_RCRC, PH_WRSKIP, PH_WRPOLL, PH_WTOKEN,
    PH_WDATA, PH_WCRC, PH_WRESP
  } phase_t;

  logic [15:0] ready_lim, token_lim;
  logic [7:0]  resp_lim;
  phase_t      phase, phase_next;
  logic [CW-1:0] bcnt, bcnt_next, hlen, hlen_next;
  logic [15:0] pcnt, pcnt_next;
  logic [2:0]  fpos, fpos_next;
  logic [5:0]  hidx, hidx_next;
  logic [31:0] harg, harg_next;
  logic        pre, pre_next;
  logic [7:0]  htok, htok_next;

  // output queue: 4 entries
  result_t   oq [4];
  logic [1:0] rd, wr;
  logic [2:0] cnt;
  result_t   r [2];
  logic [1:0] nr;

  assign q_ready = (cnt <= 3'd1);
  wire take = q_valid && q_ready;

  function automatic result_t xf(input logic [7:0] b, input logic s);
    result_t t;
    t = '0; t.kind = KIND_XFER; t.send_byte = b; t.select_active = s;
    return t;
  endfunction
  function automatic result_t dn(input logic [2:0] s, input logic [7:0] b);
    result_t t;
    t = '0; t.kind = KIND_DONE; t.status = s; t.response_byte = b; t.last = 1'b1;
    return t;
  endfunction

  logic [5:0]  cidx;
  logic [31:0] carg;
  logic [7:0]  fb;
  logic [7:0]  rlim, b;
  logic [CW-1:0] ilen;
  always_comb begin
    cidx = pre ? 6'd55 : hidx;
    carg = pre ? 32'd0 : harg;
    case (fpos_next)
      3'd0: fb = {2'b01, cidx};
      3'd1: fb = carg[31:24];
      3'd2: fb = carg[23:16];
      3'd3: fb = carg[15:8];
      3'd4: fb = carg[7:0];
      default: fb = (cidx == 6'd0) ? 8'h95 : (cidx == 6'd8) ? 8'h87 : 8'h01;
    endcase
  end

  always_comb begin
    rlim = (resp_lim == 8'd0) ? 8'd1 : resp_lim;
    b = q_item.card_byte;
    ilen = CW'(q_item.block_length);
    phase_next = phase; bcnt_next = bcnt; hlen_next = hlen; pcnt_next = pcnt;
    fpos_next = fpos; hidx_next = hidx; harg_next = harg; pre_next = pre;
    htok_next = htok;
    r[0] = '0; r[1] = '0; nr = 2'd0;
    case (q_item.cmd)
      CMD_START_CMD: begin
        hidx_next = q_item.command_index; pre_next = q_item.app_command;
        harg_next = q_item.argument; phase_next = PH_DESEL;
        r[0] = xf(8'hFF, 1'b0); nr = 2'd1;
      end
      CMD_START_READ: begin
        hlen_next = (ilen > MaxLen) ? MaxLen : ilen;
        pcnt_next = '0; phase_next = PH_TOKPOLL;
        r[0] = xf(8'hFF, 1'b1); nr = 2'd1;
      end
      CMD_START_WRITE: begin
        htok_next = q_item.data_token; phase_next = PH_WRSKIP;
        r[0] = xf(8'hFF, 1'b1); nr = 2'd1;
      end
      default: begin
        nr = 2'd1; r[0] = xf(8'hFF, 1'b1);
        case (phase)
          PH_DESEL: phase_next = PH_RSKIP;
          PH_RSKIP: begin phase_next = PH_RPOLL; pcnt_next = '0; end
          PH_RPOLL, PH_WRPOLL: begin
            if (b == 8'hFF) begin
              if (phase == PH_RPOLL) begin
                phase_next = PH_FRAME; fpos_next = 3'd0; r[0] = xf(fb, 1'b1);
              end else begin
                phase_next = PH_WTOKEN; r[0] = xf(htok, 1'b1);
              end
            end else if (pcnt < ready_lim) pcnt_next = pcnt + 16'd1;
            else begin r[0] = dn(ST_BUSY_TO, b); phase_next = PH_IDLE; end
          end
          PH_FRAME: begin
            if (fpos < 3'd5) begin
              fpos_next = fpos + 3'd1; r[0] = xf(fb, 1'b1);
            end else if (cidx == 6'd12) phase_next = PH_SKIP12;
            else begin phase_next = PH_R1; pcnt_next = 16'd1; end
          end
          PH_SKIP12: begin phase_next = PH_R1; pcnt_next = 16'd1; end
          PH_R1: begin
            if (!b[7]) begin
              if (pre && b <= 8'd1) begin
                pre_next = 1'b0; phase_next = PH_DESEL; r[0] = xf(8'hFF, 1'b0);
              end else begin
                r[0] = dn(pre ? ST_PREFIX : ST_OK, b); phase_next = PH_IDLE;
              end
            end else if (pcnt < 16'(rlim)) pcnt_next = pcnt + 16'd1;
            else begin r[0] = dn(ST_NO_R1, b); phase_next = PH_IDLE; end
          end
          PH_TOKPOLL: begin
            if (b == 8'hFF) begin
              if (pcnt < token_lim) pcnt_next = pcnt + 16'd1;
              else begin r[0] = dn(ST_TOKEN_TO, 8'hFF); phase_next = PH_IDLE; end
            end else if (b != 8'hFE) begin
              r[0] = dn(ST_BAD_TOKEN, b); phase_next = PH_IDLE;
            end else begin
              bcnt_next = '0; phase_next = (hlen != '0) ? PH_RDATA : PH_RCRC;
            end
          end
          PH_RDATA: begin
            r[0] = '0; r[0].kind = KIND_DATA; r[0].read_byte = b;
            r[1] = xf(8'hFF, 1'b1); nr = 2'd2;
            bcnt_next = bcnt + 1'b1;
            if (bcnt + 1'b1 >= hlen) begin phase_next = PH_RCRC; bcnt_next = '0; end
          end
          PH_RCRC: begin
            if (bcnt == '0) bcnt_next = CW'(1);
            else begin r[0] = dn(ST_OK, 8'hFE); phase_next = PH_IDLE; end
          end
          PH_WRSKIP: begin phase_next = PH_WRPOLL; pcnt_next = '0; end
          PH_WTOKEN: begin
            if (htok == 8'hFD) begin r[0] = dn(ST_OK, 8'h00); phase_next = PH_IDLE; end
            else begin
              phase_next = PH_WDATA; bcnt_next = CW'(1);
              r[0] = xf(q_item.write_byte, 1'b1);
            end
          end
          PH_WDATA: begin
            if (bcnt < WrLen) begin
              bcnt_next = bcnt + 1'b1; r[0] = xf(q_item.write_byte, 1'b1);
            end else begin phase_next = PH_WCRC; bcnt_next = '0; end
          end
          PH_WCRC: begin
            if (bcnt == '0) bcnt_next = CW'(1);
            else phase_next = PH_WRESP;
          end
          PH_WRESP: begin
            r[0] = dn(((b & 8'h1F) == 8'h05) ? ST_OK : ST_WR_REJECT, b);
            phase_next = PH_IDLE;
          end
          default: nr = 2'd0;
        endcase
      end
    endcase
  end

  logic deq;
  assign deq = out_valid && out_ready;
  assign out_valid = (cnt != 3'd0);
  assign out_item = oq[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_lim <= 16'hFFFF; token_lim <= 16'hFFFF; resp_lim <= 8'd10;
      phase <= PH_IDLE; bcnt <= '0; hlen <= '0; pcnt <= '0; fpos <= '0;
      hidx <= '0; harg <= '0; pre <= 1'b0; htok <= '0;
      rd <= '0; wr <= '0; cnt <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_READY_POLL: ready_lim <= cfg_data;
          REG_TOKEN_POLL: token_lim <= cfg_data;
          REG_RESP_POLL:  resp_lim  <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (take) begin
        phase <= phase_next; bcnt <= bcnt_next; hlen <= hlen_next;
        pcnt <= pcnt_next; fpos <= fpos_next; hidx <= hidx_next;
        harg <= harg_next; pre <= pre_next; htok <= htok_next;
        if (nr >= 2'd1) oq[wr] <= r[0];
        if (nr >= 2'd2) oq[wr + 2'd1] <= r[1];
        wr <= wr + nr;
      end
      if (deq) rd <= rd + 2'd1;
      cnt <= cnt + (take ? {1'b0, nr} : 3'd0) - (deq ? 3'd1 : 3'd0);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sd_spi_command_transport.sv =====
// SD SPI-mode command transport, top level.
// Depends on sdspi_pkg, sdspi_front, sdspi_engine.
//
// One item per card byte: a start item launches a command, block read or
// block write; every later item returns the card's byte for the last
// requested transfer. The block answers with a transfer request, read data
// bytes and a final done item (tlast). An item is accepted every cycle while
// at most one result is queued; a data-read item gives two results, so the
// rate follows the 4-entry output queue, which drains one result per cycle
// while m_axis_tready is high. Write config only while idle; not enforced.
`default_nettype none
module sd_spi_command_transport
  import sdspi_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES   = MaxBlockBytes,
  parameter int WRITE_BLOCK_BYTES = WriteBlockBytes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command_index, app_command, argument, block_length, data_token,
  // card_byte, write_byte (bits 0..73), zero fill to 80
  input  wire logic [79:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // send_byte, select_active, read_byte, status, response_byte (0..27)
  output logic [31:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // kind
  output logic             m_axis_tlast
);
  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_ready;

  assign in_item = {s_axis_tdata[73:0], s_axis_tuser};

  sdspi_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_item, .q_valid, .q_ready, .q_item
  );

  sdspi_engine #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES), .WRITE_BLOCK_BYTES(WRITE_BLOCK_BYTES)
  ) u_engine (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_ready, .q_item,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_item(res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {4'd0, res.response_byte, res.status, res.read_byte,
                         res.select_active, res.send_byte};
  // fields s_axis_tdata[79:74] unused by design (zero fill)
endmodule
`default_nettype wire

// ===== rtl/core/sdspi_checker.sv =====
// Port-level checker for sd_spi_command_transport, bound to the top level.
// Depends on sdspi_pkg.
`default_nettype none
module sdspi_checker
  import sdspi_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_DONE)))
    else $error("tlast not on done");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= KIND_DONE)
    else $error("bad kind");
  a_xfer: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_XFER |-> m_axis_tdata[8:0] == 9'd0)
    else $error("send byte on non-transfer");
endmodule

bind sd_spi_command_transport sdspi_checker u_chk (.*);
`default_nettype wire
